[rtl/skss_pkg.sv]
// Shared types and constants for the key-slot store.
// Used by skss_cell and secure_key_slot_store_unit; no dependencies.
`default_nettype none
package skss_pkg;

    localparam int STAGE_DEPTH = 12;

    typedef enum logic [2:0] {
        FN_CLEAR   = 3'd0,
        FN_IMPORT  = 3'd1,
        FN_STORE   = 3'd2,
        FN_LOOKUP  = 3'd3,
        FN_RD_PUB  = 3'd4,
        FN_RD_SIGN = 3'd5,
        FN_RD_CUR  = 3'd6,
        FN_NONE    = 3'd7
    } t_func;

    typedef enum logic [2:0] {
        SS_OK       = 3'd0,
        SS_STAGED   = 3'd1,
        SS_DUP      = 3'd2,
        SS_NOTFOUND = 3'd3,
        SS_FULL     = 3'd4,
        SS_BAD      = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_DONE
    } t_state;

    typedef logic [STAGE_DEPTH-1:0][63:0] t_stage;

    // Control broadcast from the sequencer to every cell
    typedef struct packed {
        logic        clear;
        logic        we_sec;
        logic        we_pub;
        logic [3:0]  wr_slot;
        t_stage      words;
        logic        cmp_init;
        logic        cmp_en;
        logic        cmp_pub;
        logic [3:0]  cmp_idx;
        logic [63:0] cmp_word;
        logic [4:0]  count;
        logic        rd_en;
        logic        rd_pub;
        logic [3:0]  rd_slot;
        logic [3:0]  rd_idx;
    } t_cell_ctl;

endpackage
`default_nettype wire

[rtl/skss_cell.sv]
// One slot of the store: secret and public key words, match flag,
// and the first-match and read-data links to the next cell. Uses skss_pkg.
`default_nettype none
module skss_cell
    import skss_pkg::*;
#(
    parameter int IDX          = 0,
    parameter int SECRET_WORDS = 4,
    parameter int PUBLIC_WORDS = 12
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_cell_ctl   i_ctl,
    input  wire logic        i_found,
    input  wire logic [3:0]  i_idx,
    input  wire logic [63:0] i_rword,
    output logic             o_found,
    output logic [3:0]       o_idx,
    output logic [63:0]      o_rword
);
    localparam int SW_BITS = (SECRET_WORDS > 1) ? $clog2(SECRET_WORDS) : 1;
    localparam int PW_BITS = (PUBLIC_WORDS > 1) ? $clog2(PUBLIC_WORDS) : 1;
    localparam logic [3:0] MY_SLOT = 4'(IDX);
    localparam logic [4:0] MY_SLOT5 = 5'(IDX);

    logic [SECRET_WORDS-1:0][63:0] r_sec;
    logic [PUBLIC_WORDS-1:0][63:0] r_pub;
    logic                          r_match;
    logic [63:0]                   cmp_mine;
    logic [63:0]                   rd_mine;
    logic                          hit;

    // Hold key words; zero on reset and clear
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear) begin
            r_sec <= '0;
            r_pub <= '0;
        end else begin
            if (i_ctl.we_sec && i_ctl.wr_slot == MY_SLOT) begin
                for (int w = 0; w < SECRET_WORDS; w++) r_sec[w] <= i_ctl.words[w];
            end
            if (i_ctl.we_pub && i_ctl.wr_slot == MY_SLOT) begin
                for (int w = 0; w < PUBLIC_WORDS; w++) r_pub[w] <= i_ctl.words[w];
            end
        end
    end

    // Compare one word per cycle against the staged key while compare is enabled
    assign cmp_mine = i_ctl.cmp_pub ? r_pub[i_ctl.cmp_idx[PW_BITS-1:0]]
                                    : r_sec[i_ctl.cmp_idx[SW_BITS-1:0]];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match <= 1'b0;
        end else if (i_ctl.cmp_init) begin
            r_match <= 1'b1;
        end else if (i_ctl.cmp_en) begin
            r_match <= r_match & (cmp_mine == i_ctl.cmp_word);
        end
    end

    // Pass first-match token and slot number to the neighbor
    assign hit     = r_match && (MY_SLOT5 < i_ctl.count);
    assign o_found = i_found | hit;
    assign o_idx   = (hit && !i_found) ? MY_SLOT : i_idx;

    // Merge this slot's word into the read chain when selected
    assign rd_mine = i_ctl.rd_pub ? r_pub[i_ctl.rd_idx[PW_BITS-1:0]]
                                  : r_sec[i_ctl.rd_idx[SW_BITS-1:0]];
    assign o_rword = (i_ctl.rd_en && i_ctl.rd_slot == MY_SLOT) ? (i_rword | rd_mine)
                                                               : i_rword;
endmodule
`default_nettype wire

[rtl/secure_key_slot_store_unit.sv]
// Top level of the key-slot store: staging buffer, sequencer, cell chain.
// Depends on skss_pkg and skss_cell.
//
// Usage: drive i_func, i_data_word, i_word_index, i_last_word and i_slot
// with start high; the transaction is taken at an edge where busy is low.
// Each transaction gives one result, shown on o_status, o_key_count,
// o_read_word and o_match_slot for one cycle while o_done is high.
// Staged words, store public, clear and the three word reads finish
// without busy: o_done rises the cycle after start, and busy stays low.
// A final word of an import compares the SECRET_WORDS secret words, a
// final word of a lookup the PUBLIC_WORDS public words, in every cell
// at once in the compare state; the done state then resolves the first
// match through the cell chain and commits, with busy high throughout.
// Reset zeroes all slots, the count and the signing selection; the
// staging buffer is undefined until written. The receiver cannot stall:
// results must be taken in the cycle o_done is high.
`default_nettype none
module secure_key_slot_store_unit
    import skss_pkg::*;
#(
    parameter int SLOT_COUNT   = 16,
    parameter int PUBLIC_WORDS = 12,
    parameter int SECRET_WORDS = 4
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [2:0]  i_func,
    input  wire logic [63:0] i_data_word,
    input  wire logic [3:0]  i_word_index,
    input  wire logic        i_last_word,
    input  wire logic [3:0]  i_slot,
    output logic             o_done,
    output logic [2:0]       o_status,
    output logic [4:0]       o_key_count,
    output logic [63:0]      o_read_word,
    output logic [3:0]       o_match_slot
);
    localparam logic [4:0] SLOTS5 = 5'(SLOT_COUNT);
    localparam logic [3:0] SEC_LAST = 4'(SECRET_WORDS - 1);
    localparam logic [3:0] PUB_LAST = 4'(PUBLIC_WORDS - 1);

    t_state      r_state, n_state;
    logic [3:0]  r_cnt, n_cnt;
    logic        r_lookup, n_lookup;
    logic [4:0]  r_count, n_count;
    logic [3:0]  r_cur, n_cur;
    logic [3:0]  r_sign, n_sign;
    logic        r_sign_v, n_sign_v;
    t_stage      r_stage, n_stage;
    logic        r_done, n_done;
    logic [2:0]  r_status, n_status;
    logic [63:0] r_rword, n_rword;
    logic [3:0]  r_match, n_match;

    t_cell_ctl   ctl;
    t_func       func;
    logic        accept;
    logic [SLOT_COUNT:0]       ch_found;
    logic [SLOT_COUNT:0][3:0]  ch_idx;
    logic [SLOT_COUNT:0][63:0] ch_rword;

    assign func   = t_func'(i_func);
    assign accept = start && (r_state == ST_IDLE);
    assign busy   = (r_state != ST_IDLE);

    // Merge the incoming word into the staging buffer
    always_comb begin
        n_stage = r_stage;
        if (accept && (func == FN_IMPORT || func == FN_STORE || func == FN_LOOKUP)
                && i_word_index < 4'(STAGE_DEPTH)) begin
            n_stage[i_word_index] = i_data_word;
        end
    end

    always_ff @(posedge i_clk) begin
        r_stage <= n_stage;
    end

    // Cell chain
    assign ch_found[0] = 1'b0;
    assign ch_idx[0]   = '0;
    assign ch_rword[0] = '0;

    for (genvar k = 0; k < SLOT_COUNT; k++) begin : g_cell
        skss_cell #(
            .IDX          (k),
            .SECRET_WORDS (SECRET_WORDS),
            .PUBLIC_WORDS (PUBLIC_WORDS)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (ctl),
            .i_found (ch_found[k]),
            .i_idx   (ch_idx[k]),
            .i_rword (ch_rword[k]),
            .o_found (ch_found[k+1]),
            .o_idx   (ch_idx[k+1]),
            .o_rword (ch_rword[k+1])
        );
    end

    // Sequencer: next state, cell control and result
    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_lookup = r_lookup;
        n_count  = r_count;
        n_cur    = r_cur;
        n_sign   = r_sign;
        n_sign_v = r_sign_v;
        n_done   = 1'b0;
        n_status = r_status;
        n_rword  = r_rword;
        n_match  = r_match;

        ctl          = '0;
        ctl.words    = n_stage;
        ctl.count    = r_count;
        ctl.cmp_pub  = r_lookup;
        ctl.cmp_idx  = r_cnt;
        ctl.cmp_word = r_stage[r_cnt];
        ctl.rd_idx   = i_word_index;

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_done   = 1'b1;
                    n_status = SS_OK;
                    n_rword  = '0;
                    n_match  = '0;
                    case (func)
                        FN_CLEAR: begin
                            ctl.clear = 1'b1;
                            n_count   = '0;
                            n_cur     = '0;
                            n_sign    = '0;
                            n_sign_v  = 1'b0;
                        end
                        FN_IMPORT, FN_LOOKUP: begin
                            if (!i_last_word) begin
                                n_status = SS_STAGED;
                            end else begin
                                n_done       = 1'b0;
                                ctl.cmp_init = 1'b1;
                                n_lookup     = (func == FN_LOOKUP);
                                n_cnt        = '0;
                                n_state      = ST_CMP;
                            end
                        end
                        FN_STORE: begin
                            if (!i_last_word) begin
                                n_status = SS_STAGED;
                            end else if (r_count == '0) begin
                                n_status = SS_BAD;
                            end else begin
                                ctl.we_pub  = 1'b1;
                                ctl.wr_slot = 4'(r_count - 5'd1);
                            end
                        end
                        FN_RD_PUB: begin
                            ctl.rd_en   = 1'b1;
                            ctl.rd_pub  = 1'b1;
                            ctl.rd_slot = i_slot;
                            if ({1'b0, i_slot} < r_count && i_word_index < PUB_LAST + 4'd1
                                    && i_word_index <= PUB_LAST) begin
                                n_rword = ch_rword[SLOT_COUNT];
                            end else begin
                                n_status = SS_BAD;
                            end
                        end
                        FN_RD_SIGN: begin
                            ctl.rd_en   = 1'b1;
                            ctl.rd_slot = r_sign;
                            if (r_sign_v && i_word_index <= SEC_LAST) begin
                                n_rword = ch_rword[SLOT_COUNT];
                            end else begin
                                n_status = SS_BAD;
                            end
                        end
                        FN_RD_CUR: begin
                            ctl.rd_en   = 1'b1;
                            ctl.rd_slot = r_cur;
                            if (r_count != '0 && i_word_index <= SEC_LAST) begin
                                n_rword = ch_rword[SLOT_COUNT];
                            end else begin
                                n_status = SS_BAD;
                            end
                        end
                        default: begin
                            n_status = SS_BAD;
                        end
                    endcase
                end
            end
            ST_CMP: begin
                ctl.cmp_en = 1'b1;
                n_cnt      = r_cnt + 4'd1;
                if (r_cnt == (r_lookup ? PUB_LAST : SEC_LAST)) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                n_state = ST_IDLE;
                n_done  = 1'b1;
                n_rword = '0;
                n_match = '0;
                if (r_lookup) begin
                    if (ch_found[SLOT_COUNT]) begin
                        n_status = SS_OK;
                        n_sign   = ch_idx[SLOT_COUNT];
                        n_sign_v = 1'b1;
                        n_match  = ch_idx[SLOT_COUNT];
                    end else begin
                        n_status = SS_NOTFOUND;
                    end
                end else if (ch_found[SLOT_COUNT]) begin
                    n_status = SS_DUP;
                end else if (r_count >= SLOTS5) begin
                    n_status = SS_FULL;
                end else begin
                    n_status    = SS_OK;
                    ctl.we_sec  = 1'b1;
                    ctl.wr_slot = r_count[3:0];
                    n_cur       = r_count[3:0];
                    n_count     = r_count + 5'd1;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_cnt    <= '0;
            r_lookup <= 1'b0;
            r_count  <= '0;
            r_cur    <= '0;
            r_sign   <= '0;
            r_sign_v <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_lookup <= n_lookup;
            r_count  <= n_count;
            r_cur    <= n_cur;
            r_sign   <= n_sign;
            r_sign_v <= n_sign_v;
            r_done   <= n_done;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_rword  <= n_rword;
        r_match  <= n_match;
    end

    assign o_done       = r_done;
    assign o_status     = r_status;
    assign o_key_count  = r_count;
    assign o_read_word  = r_rword;
    assign o_match_slot = r_match;

`ifndef SYNTHESIS
    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result strobe while busy");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_key_count <= SLOTS5)
        else $error("slot count beyond capacity");
    a_full_means_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status == SS_FULL) |-> (o_key_count == SLOTS5))
        else $error("store full reported with free slots");
    a_match_only_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_match_slot != 4'd0) |-> (o_status == SS_OK))
        else $error("match slot set on failed transaction");
`endif

endmodule
`default_nettype wire
